// ----- hdl/igmpjl_pkg.sv -----
// ----------------------------------------------------------------------------
// igmpjl_pkg
// Shared types and constants for the IGMPv2 join/leave frame builder.
// ----------------------------------------------------------------------------
package igmpjl_pkg;

    localparam int unsigned FRAME_LEN  = 46;
    localparam logic [5:0]  LAST_INDEX = 6'd45;

    localparam logic [7:0]  IGMP_REPORT = 8'h16;
    localparam logic [7:0]  IGMP_LEAVE  = 8'h17;

    // Constant IPv4 header words: 0x4600 + 0x0020 + 0x0102 + 0x9404
    localparam logic [15:0] IP_CONST_SUM = 16'hDB26;

    localparam logic [1:0]  REG_SOURCE_MAC = 2'd0;
    localparam logic [1:0]  REG_SOURCE_IP  = 2'd1;
    localparam logic [1:0]  REG_IP_IDENT   = 2'd2;

    localparam logic [47:0] SOURCE_MAC_RST = 48'h00808E010203;
    localparam logic [31:0] SOURCE_IP_RST  = 32'hC0A80001;
    localparam logic [15:0] IP_IDENT_RST   = 16'h58DD;

    typedef struct packed {
        logic        join_req;
        logic [31:0] group_address;
        logic [15:0] ip_cksum;
        logic [15:0] igmp_cksum;
    } frame_desc_t;

endpackage

// ----- hdl/igmpjl_cksum.sv -----
// ----------------------------------------------------------------------------
// igmpjl_cksum
// Three-stage checksum pipeline: partial sums, combine, end-around fold.
// ----------------------------------------------------------------------------
module igmpjl_cksum (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     join_req,
    input  logic [31:0]              group_address,
    input  logic [31:0]              source_ip,
    input  logic [15:0]              ip_ident,
    output logic                     out_valid,
    input  logic                     out_ready,
    output igmpjl_pkg::frame_desc_t  out_desc
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;

    logic        join1_reg, join2_reg;
    logic [31:0] grp1_reg, grp2_reg;
    logic [17:0] ip_a1_reg, ip_b1_reg, ig1_reg;
    logic [18:0] ip_s2_reg;
    logic [16:0] ig_f2_reg;
    igmpjl_pkg::frame_desc_t desc3_reg;

    logic [7:0]  igmp_type;
    logic [16:0] ip_f1;
    logic [15:0] ip_f2;
    logic [15:0] ig_f2;

    assign adv3     = out_ready || !v3_reg;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign igmp_type = join_req ? igmpjl_pkg::IGMP_REPORT : igmpjl_pkg::IGMP_LEAVE;

    assign ip_f1 = {14'd0, ip_s2_reg[18:16]} + {1'b0, ip_s2_reg[15:0]};
    assign ip_f2 = ip_f1[15:0] + {15'd0, ip_f1[16]};
    assign ig_f2 = ig_f2_reg[15:0] + {15'd0, ig_f2_reg[16]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            join1_reg <= join_req;
            grp1_reg  <= group_address;
            ip_a1_reg <= {2'd0, igmpjl_pkg::IP_CONST_SUM} + {2'd0, ip_ident}
                         + {2'd0, source_ip[31:16]};
            ip_b1_reg <= {2'd0, source_ip[15:0]} + {2'd0, group_address[31:16]}
                         + {2'd0, group_address[15:0]};
            ig1_reg   <= {2'd0, igmp_type, 8'h00} + {2'd0, group_address[31:16]}
                         + {2'd0, group_address[15:0]};
        end
        if (adv2) begin
            join2_reg <= join1_reg;
            grp2_reg  <= grp1_reg;
            ip_s2_reg <= {1'b0, ip_a1_reg} + {1'b0, ip_b1_reg};
            ig_f2_reg <= {15'd0, ig1_reg[17:16]} + {1'b0, ig1_reg[15:0]};
        end
        if (adv3) begin
            desc3_reg.join_req      <= join2_reg;
            desc3_reg.group_address <= grp2_reg;
            desc3_reg.ip_cksum      <= ~ip_f2;
            desc3_reg.igmp_cksum    <= ~ig_f2;
        end
    end

    assign out_valid = v3_reg;
    assign out_desc  = desc3_reg;

endmodule

// ----- hdl/igmpjl_ser.sv -----
// ----------------------------------------------------------------------------
// igmpjl_ser
// Frame serialiser: holds one frame descriptor and sends it a byte per transfer.
// ----------------------------------------------------------------------------
module igmpjl_ser (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  igmpjl_pkg::frame_desc_t  in_desc,
    input  logic [47:0]              source_mac,
    input  logic [31:0]              source_ip,
    input  logic [15:0]              ip_ident,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_frame_byte,
    output logic [5:0]               m_byte_index,
    output logic                     m_last_byte
);

    igmpjl_pkg::frame_desc_t desc_reg;
    logic        busy_reg;
    logic [5:0]  idx_reg;
    logic        last;
    logic [31:0] g;
    logic [7:0]  igmp_type;

    assign last     = (idx_reg == igmpjl_pkg::LAST_INDEX);
    assign in_ready = !busy_reg || (m_ready && last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 6'd0;
        end else if (in_ready) begin
            busy_reg <= in_valid;
            idx_reg  <= 6'd0;
        end else if (m_ready) begin
            idx_reg <= idx_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            desc_reg <= in_desc;
        end
    end

    assign g         = desc_reg.group_address;
    assign igmp_type = desc_reg.join_req ? igmpjl_pkg::IGMP_REPORT : igmpjl_pkg::IGMP_LEAVE;

    always_comb begin
        case (idx_reg)
            6'd0:    m_frame_byte = 8'h01;
            6'd2:    m_frame_byte = 8'h5E;
            6'd3:    m_frame_byte = {1'b0, g[22:16]};
            6'd4:    m_frame_byte = g[15:8];
            6'd5:    m_frame_byte = g[7:0];
            6'd6:    m_frame_byte = source_mac[47:40];
            6'd7:    m_frame_byte = source_mac[39:32];
            6'd8:    m_frame_byte = source_mac[31:24];
            6'd9:    m_frame_byte = source_mac[23:16];
            6'd10:   m_frame_byte = source_mac[15:8];
            6'd11:   m_frame_byte = source_mac[7:0];
            6'd12:   m_frame_byte = 8'h08;
            6'd14:   m_frame_byte = 8'h46;
            6'd17:   m_frame_byte = 8'h20;
            6'd18:   m_frame_byte = ip_ident[15:8];
            6'd19:   m_frame_byte = ip_ident[7:0];
            6'd22:   m_frame_byte = 8'h01;
            6'd23:   m_frame_byte = 8'h02;
            6'd24:   m_frame_byte = desc_reg.ip_cksum[15:8];
            6'd25:   m_frame_byte = desc_reg.ip_cksum[7:0];
            6'd26:   m_frame_byte = source_ip[31:24];
            6'd27:   m_frame_byte = source_ip[23:16];
            6'd28:   m_frame_byte = source_ip[15:8];
            6'd29:   m_frame_byte = source_ip[7:0];
            6'd30:   m_frame_byte = g[31:24];
            6'd31:   m_frame_byte = g[23:16];
            6'd32:   m_frame_byte = g[15:8];
            6'd33:   m_frame_byte = g[7:0];
            6'd34:   m_frame_byte = 8'h94;
            6'd35:   m_frame_byte = 8'h04;
            6'd38:   m_frame_byte = igmp_type;
            6'd40:   m_frame_byte = desc_reg.igmp_cksum[15:8];
            6'd41:   m_frame_byte = desc_reg.igmp_cksum[7:0];
            6'd42:   m_frame_byte = g[31:24];
            6'd43:   m_frame_byte = g[23:16];
            6'd44:   m_frame_byte = g[15:8];
            6'd45:   m_frame_byte = g[7:0];
            default: m_frame_byte = 8'h00;
        endcase
    end

    assign m_valid      = busy_reg;
    assign m_byte_index = idx_reg;
    assign m_last_byte  = last;

endmodule

// ----- hdl/igmpv2_join_leave_frame_builder_unit.sv -----
// ----------------------------------------------------------------------------
// igmpv2_join_leave_frame_builder_unit
// Builds a 46-byte Ethernet/IPv4/IGMPv2 join or leave frame per request.
// ----------------------------------------------------------------------------
// Each request produces 46 byte transfers, so the sustained request rate is
// set by the byte-wide output. Checksums are worked out in a three-stage
// pipeline ahead of the serialiser, which starts a new frame in the cycle
// after the last byte of the previous one is taken when the next descriptor
// is already waiting. Registers at 0x00 (source MAC), 0x08 (source IP) and
// 0x10 (IP identification) are read live and must only be written while
// no frame is in flight.
module igmpv2_join_leave_frame_builder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_join_req,
    input  logic [31:0] s_group_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic [5:0]  m_byte_index,
    output logic        m_last_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [47:0] source_mac_reg;
    logic [31:0] source_ip_reg;
    logic [15:0] ip_ident_reg;
    logic [1:0]  reg_sel;
    logic        cfg_wr;

    logic                    ck_valid;
    logic                    ck_ready;
    igmpjl_pkg::frame_desc_t ck_desc;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_mac_reg <= igmpjl_pkg::SOURCE_MAC_RST;
            source_ip_reg  <= igmpjl_pkg::SOURCE_IP_RST;
            ip_ident_reg   <= igmpjl_pkg::IP_IDENT_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                igmpjl_pkg::REG_SOURCE_MAC: source_mac_reg <= pwdata[47:0];
                igmpjl_pkg::REG_SOURCE_IP:  source_ip_reg  <= pwdata[31:0];
                igmpjl_pkg::REG_IP_IDENT:   ip_ident_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            igmpjl_pkg::REG_SOURCE_MAC: prdata = {16'd0, source_mac_reg};
            igmpjl_pkg::REG_SOURCE_IP:  prdata = {32'd0, source_ip_reg};
            igmpjl_pkg::REG_IP_IDENT:   prdata = {48'd0, ip_ident_reg};
            default:                    prdata = 64'd0;
        endcase
    end

    igmpjl_cksum u_cksum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .join_req      (s_join_req),
        .group_address (s_group_address),
        .source_ip     (source_ip_reg),
        .ip_ident      (ip_ident_reg),
        .out_valid     (ck_valid),
        .out_ready     (ck_ready),
        .out_desc      (ck_desc)
    );

    igmpjl_ser u_ser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (ck_valid),
        .in_ready     (ck_ready),
        .in_desc      (ck_desc),
        .source_mac   (source_mac_reg),
        .source_ip    (source_ip_reg),
        .ip_ident     (ip_ident_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_byte_index (m_byte_index),
        .m_last_byte  (m_last_byte)
    );

endmodule

// ----- hdl/igmpjl_checker.sv -----
// ----------------------------------------------------------------------------
// igmpjl_checker
// Port-level checks on the frame output of the frame builder.
// ----------------------------------------------------------------------------
module igmpjl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_frame_byte,
    input logic [5:0]  m_byte_index,
    input logic        m_last_byte
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_byte) && $stable(m_byte_index))
        else $error("output changed while stalled");

    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_byte |=>
            m_valid && (m_byte_index == $past(m_byte_index) + 6'd1))
        else $error("frame byte index did not advance by one");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_byte |-> m_byte_index == 6'd45)
        else $error("last byte marker on wrong index");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_byte |=> !m_valid || m_byte_index == 6'd0)
        else $error("new frame did not start at index zero");

    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_index == 6'd0 |-> m_frame_byte == 8'h01)
        else $error("destination MAC does not start with the multicast prefix");

endmodule

bind igmpv2_join_leave_frame_builder_unit igmpjl_checker u_igmpjl_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_byte (m_frame_byte),
    .m_byte_index (m_byte_index),
    .m_last_byte  (m_last_byte)
);

// ----- bench/igmp_frame_checker.sv -----
// ----------------------------------------------------------------------------
// igmp_frame_checker
// Predicts and checks the byte stream of the IGMPv2 join/leave frame builder.
// ----------------------------------------------------------------------------
// Mirrors the configuration registers from the APB writes it sees. Each input
// transfer is expanded into the 46 bytes of its frame, with both checksums
// worked out here. Each output transfer is checked field by field against
// the oldest byte still due.
// ----------------------------------------------------------------------------
module igmp_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_join_req,
    input  logic [31:0] s_group_address,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_frame_byte,
    input  logic [5:0]  m_byte_index,
    input  logic        m_last_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          pending_bytes,
    output int          mismatches
);

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IPV4_VER_IHL   = 8'h46;
    localparam logic [15:0] IPV4_TOTAL_LEN = 16'd32;
    localparam logic [7:0]  IPV4_TTL       = 8'h01;
    localparam logic [7:0]  IP_PROTO_IGMP  = 8'h02;
    localparam logic [31:0] RA_OPTION_WORD = 32'h9404_0000;
    localparam int          IP_HDR_OFS     = 14;
    localparam int          IGMP_OFS       = 38;

    typedef struct packed {
        logic [7:0] value;
        logic [5:0] index;
        logic       last;
    } frame_byte_t;

    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [15:0] ident;
    frame_byte_t frame_bytes_due[$];
    int          errors = 0;

    function automatic logic [15:0] ones_cksum(
        input logic [7:0] fr [igmpjl_pkg::FRAME_LEN],
        input int first, input int words);
        logic [31:0] acc;
        acc = '0;
        for (int w = 0; w < words; w++)
            acc += {16'h0, fr[first + 2 * w], fr[first + 2 * w + 1]};
        acc = {16'h0, acc[31:16]} + {16'h0, acc[15:0]};
        acc = acc + {16'h0, acc[31:16]};
        return ~acc[15:0];
    endfunction

    function automatic void build_frame_bytes(input logic is_join, input logic [31:0] grp);
        logic [7:0]  fr [igmpjl_pkg::FRAME_LEN];
        frame_byte_t fb;
        fr[0] = 8'h01;
        fr[1] = 8'h00;
        fr[2] = 8'h5E;
        fr[3] = {1'b0, grp[22:16]};
        fr[4] = grp[15:8];
        fr[5] = grp[7:0];
        for (int i = 0; i < 6; i++)
            fr[6 + i] = src_mac[47 - 8 * i -: 8];
        {fr[12], fr[13]} = ETHERTYPE_IPV4;
        fr[14] = IPV4_VER_IHL;
        fr[15] = 8'h00;
        {fr[16], fr[17]} = IPV4_TOTAL_LEN;
        {fr[18], fr[19]} = ident;
        {fr[20], fr[21]} = 16'h0000;
        fr[22] = IPV4_TTL;
        fr[23] = IP_PROTO_IGMP;
        {fr[24], fr[25]} = 16'h0000;
        {fr[26], fr[27], fr[28], fr[29]} = src_ip;
        {fr[30], fr[31], fr[32], fr[33]} = grp;
        {fr[34], fr[35], fr[36], fr[37]} = RA_OPTION_WORD;
        {fr[24], fr[25]} = ones_cksum(fr, IP_HDR_OFS, 12);
        fr[38] = is_join ? igmpjl_pkg::IGMP_REPORT : igmpjl_pkg::IGMP_LEAVE;
        fr[39] = 8'h00;
        {fr[40], fr[41]} = 16'h0000;
        {fr[42], fr[43], fr[44], fr[45]} = grp;
        {fr[40], fr[41]} = ones_cksum(fr, IGMP_OFS, 4);
        for (int i = 0; i < igmpjl_pkg::FRAME_LEN; i++) begin
            fb.value = fr[i];
            fb.index = 6'(i);
            fb.last  = (6'(i) == igmpjl_pkg::LAST_INDEX);
            frame_bytes_due.push_back(fb);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        frame_byte_t due;
        if (!aresetn) begin
            src_mac = igmpjl_pkg::SOURCE_MAC_RST;
            src_ip  = igmpjl_pkg::SOURCE_IP_RST;
            ident   = igmpjl_pkg::IP_IDENT_RST;
            frame_bytes_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    igmpjl_pkg::REG_SOURCE_MAC: src_mac = pwdata[47:0];
                    igmpjl_pkg::REG_SOURCE_IP:  src_ip  = pwdata[31:0];
                    igmpjl_pkg::REG_IP_IDENT:   ident   = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    $error("frame_byte: expected none, actual %h (index %0d)",
                           m_frame_byte, m_byte_index);
                    errors++;
                end else begin
                    due = frame_bytes_due.pop_front();
                    if (m_frame_byte !== due.value) begin
                        $error("frame_byte: expected %h, actual %h", due.value, m_frame_byte);
                        errors++;
                    end
                    if (m_byte_index !== due.index) begin
                        $error("byte_index: expected %0d, actual %0d", due.index, m_byte_index);
                        errors++;
                    end
                    if (m_last_byte !== due.last) begin
                        $error("last_byte: expected %b, actual %b", due.last, m_last_byte);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                build_frame_bytes(s_join_req, s_group_address);
        end
        pending_bytes <= frame_bytes_due.size();
        mismatches    <= errors;
    end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the IGMPv2 join/leave frame builder.
// ----------------------------------------------------------------------------
// Directed requests cover the group address extremes, join and leave, and
// non-multicast groups under reset, all-zero and all-one register settings.
// Random requests follow in three phases with different idling on each side,
// the last one opening with a long receiver hold-off. Registers are written
// only once every due byte has gone out.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 11;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          STALL_LIMIT   = 3000;
    localparam int          PHASE_ITEMS   = 64;
    localparam logic [1:0]  REG_UNMAPPED  = 2'd3;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_join_req      = 1'b0;
    logic [31:0] s_group_address = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_frame_byte;
    logic [5:0]  m_byte_index;
    logic        m_last_byte;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b1;
    logic [4:0]  paddr           = '0;
    logic [63:0] pwdata          = '0;
    logic [63:0] prdata;
    logic        pready;

    int pending_bytes;
    int mismatches;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int holds_asked = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    igmpv2_join_leave_frame_builder_unit dut (.*);

    igmp_frame_checker u_frame_checker (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_join_req, .s_group_address,
        .m_valid, .m_ready, .m_frame_byte, .m_byte_index, .m_last_byte,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .pending_bytes, .mismatches
    );

    task automatic send_request(input logic is_join, input logic [31:0] grp);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_join_req      <= is_join;
        s_group_address <= grp;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering, then let every due byte out
    task automatic drain_frames();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_bytes != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : receiver
        int holds_given;
        holds_given = 0;
        forever begin
            @(posedge aclk);
            if (holds_asked > holds_given) begin
                holds_given++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL igmpv2_join_leave_frame_builder_unit");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] corner_groups [10];
        logic [31:0] grp;
        corner_groups = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hE000_0001, 32'hEFFF_FFFF,
                          32'hE000_0016, 32'h0A00_0001, 32'hE080_0000, 32'hE07F_FFFF,
                          32'h5555_5555, 32'hAAAA_AAAA};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn     <= 1'b1;
        tx_idle_pct  = 10;
        rx_idle_pct <= 52;
        @(posedge aclk);

        // reset register values
        foreach (corner_groups[i])
            send_request(i % 2 == 0, corner_groups[i]);
        send_request(1'b1, 32'hFFFF_FFFF);
        send_request(1'b0, 32'h0000_0000);
        drain_frames();

        write_reg(igmpjl_pkg::REG_SOURCE_MAC, '0);
        write_reg(igmpjl_pkg::REG_SOURCE_IP, '0);
        write_reg(igmpjl_pkg::REG_IP_IDENT, '0);
        send_request(1'b1, 32'h0000_0000);
        send_request(1'b0, 32'hFFFF_FFFF);
        send_request(1'b1, 32'hE000_0001);
        drain_frames();

        // over-wide values keep only the register width
        write_reg(igmpjl_pkg::REG_SOURCE_MAC, '1);
        write_reg(igmpjl_pkg::REG_SOURCE_IP, '1);
        write_reg(igmpjl_pkg::REG_IP_IDENT, '1);
        send_request(1'b0, 32'h0000_0000);
        send_request(1'b1, 32'hFFFF_FFFF);
        send_request(1'b0, 32'hEFFF_FFFF);
        drain_frames();

        // unmapped register: write dropped
        write_reg(REG_UNMAPPED, {$urandom, $urandom});
        send_request(1'b1, 32'hE000_00FB);
        drain_frames();

        for (int p = 0; p < 3; p++) begin
            tx_idle_pct  = (p == 0) ? 10 : (p == 1) ? 52 : 0;
            rx_idle_pct <= (p == 0) ? 52 : (p == 1) ? 10 : 0;
            write_reg(igmpjl_pkg::REG_SOURCE_MAC, {$urandom, $urandom});
            write_reg(igmpjl_pkg::REG_SOURCE_IP, {$urandom, $urandom});
            write_reg(igmpjl_pkg::REG_IP_IDENT, {$urandom, $urandom});
            if (p == 2)
                holds_asked <= holds_asked + 1;
            repeat (PHASE_ITEMS) begin
                grp = $urandom;
                if ($urandom_range(99) < 75)
                    grp[31:28] = 4'hE;
                send_request(1'($urandom), grp);
            end
            drain_frames();
        end

        if (mismatches == 0)
            $display("PASS igmpv2_join_leave_frame_builder_unit");
        else
            $display("FAIL igmpv2_join_leave_frame_builder_unit");
        $finish;
    end

endmodule
